// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the tile collision test RTL.
// Files that check their own logic include this header; it depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while rst_n is low.
`define TCTU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TCTU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/tctu_pkg.sv =====
// Types and fixed constants for the tile collision test unit.
// Used by tctu_isqrt, tctu_div and tile_collision_test_unit; depends on nothing.
`default_nettype none

package tctu_pkg;

    localparam int POS_W     = 32;
    localparam int RAD_W     = 16;
    localparam int SIZE_W    = 20;
    localparam int IDX_W     = 12;
    localparam int TS_W      = 11;
    localparam int DEPTH_W   = 28;
    localparam int VEC_W     = 16;

    // distance math: root of (d2 << 28), Q1.14 unit vectors
    localparam int D2_W      = 33;
    localparam int SQ_SCALE  = 28;
    localparam int SQ_IN_W   = 60;
    localparam int SQ_W      = 30;
    localparam int SQ_STAGES = 30;
    localparam int UNIT_SHIFT = 14;
    localparam int NUM_W     = 46;
    localparam int Q_W       = 16;

    localparam logic [TS_W-1:0]         TILE_SIZE_RESET = 11'd64;
    localparam logic signed [VEC_W-1:0] UNIT_POS = 16'sd16384;
    localparam logic signed [VEC_W-1:0] UNIT_NEG = -16'sd16384;
    localparam logic [SQ_W-1:0]         DIST_ROUND = 30'd8192;

    typedef struct packed {
        logic                     is_circle;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [RAD_W-1:0]         circle_radius;
        logic [SIZE_W-1:0]        rect_width;
        logic [SIZE_W-1:0]        rect_height;
        logic [IDX_W-1:0]         tile_col;
        logic [IDX_W-1:0]         tile_row;
    } tctu_in_t;

    typedef struct packed {
        logic                     collided;
        logic                     centre_inside;
        logic [DEPTH_W-1:0]       overlap_depth;
        logic signed [VEC_W-1:0]  normal_x;
        logic signed [VEC_W-1:0]  normal_y;
        logic signed [VEC_W-1:0]  tangent_x;
        logic signed [VEC_W-1:0]  tangent_y;
    } tctu_out_t;

    // partial result that rides along the root and divide pipelines
    typedef struct packed {
        logic                     collided;
        logic                     centre_inside;
        logic [DEPTH_W-1:0]       depth;
        logic signed [VEC_W-1:0]  nx;
        logic signed [VEC_W-1:0]  ny;
        logic                     need_math;
        logic [RAD_W-1:0]         rad;
        logic [RAD_W-1:0]         ax;
        logic [RAD_W-1:0]         ay;
        logic                     sx;
        logic                     sy;
    } tctu_side_t;

endpackage

`default_nettype wire

// ===== hdl/tctu_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on tctu_pkg.
`default_nettype none

module tctu_isqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [tctu_pkg::SQ_IN_W-1:0] in_val,
    input  wire tctu_pkg::tctu_side_t        in_side,
    output logic                             out_valid,
    output logic [tctu_pkg::SQ_W-1:0]        out_root,
    output tctu_pkg::tctu_side_t             out_side
);
    import tctu_pkg::*;

    logic                 vld_reg  [SQ_STAGES];
    logic [SQ_IN_W-1:0]   rem_reg  [SQ_STAGES];
    logic [SQ_IN_W-1:0]   res_reg  [SQ_STAGES];
    tctu_side_t           side_reg [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
        localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (2 * (SQ_STAGES - 1 - g));
        logic               cur_vld;
        logic [SQ_IN_W-1:0] cur_rem;
        logic [SQ_IN_W-1:0] cur_res;
        tctu_side_t         cur_side;
        logic [SQ_IN_W:0]   trial;
        logic               take;
        logic [SQ_IN_W-1:0] rem_next;
        logic [SQ_IN_W-1:0] res_next;

        if (g == 0) begin : g_head
            assign cur_vld  = in_valid;
            assign cur_rem  = in_val;
            assign cur_res  = '0;
            assign cur_side = in_side;
        end
        else begin : g_body
            assign cur_vld  = vld_reg[g-1];
            assign cur_rem  = rem_reg[g-1];
            assign cur_res  = res_reg[g-1];
            assign cur_side = side_reg[g-1];
        end

        assign trial    = {1'b0, cur_res} + {1'b0, BIT};
        assign take     = {1'b0, cur_rem} >= trial;
        assign rem_next = take ? cur_rem - trial[SQ_IN_W-1:0] : cur_rem;
        assign res_next = take ? (cur_res >> 1) + BIT : cur_res >> 1;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                res_reg[g]  <= res_next;
                side_reg[g] <= cur_side;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign out_root  = res_reg[SQ_STAGES-1][SQ_W-1:0];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/tctu_div.sv =====
// Two restoring dividers sharing one divisor, one quotient bit per stage.
// Depends on tctu_pkg.
`default_nettype none

module tctu_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [tctu_pkg::NUM_W-1:0] in_num_x,
    input  wire logic [tctu_pkg::NUM_W-1:0] in_num_y,
    input  wire logic [tctu_pkg::SQ_W-1:0]  in_den,
    input  wire tctu_pkg::tctu_side_t      in_side,
    output logic                           out_valid,
    output logic [tctu_pkg::Q_W-1:0]       out_qx,
    output logic [tctu_pkg::Q_W-1:0]       out_qy,
    output tctu_pkg::tctu_side_t           out_side
);
    import tctu_pkg::*;

    logic               vld_reg  [Q_W];
    logic [NUM_W-1:0]   rx_reg   [Q_W];
    logic [NUM_W-1:0]   ry_reg   [Q_W];
    logic [Q_W-1:0]     qx_reg   [Q_W];
    logic [Q_W-1:0]     qy_reg   [Q_W];
    logic [SQ_W-1:0]    den_reg  [Q_W];
    tctu_side_t         side_reg [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        localparam int B = Q_W - 1 - g;
        logic             cur_vld;
        logic [NUM_W-1:0] cur_rx;
        logic [NUM_W-1:0] cur_ry;
        logic [Q_W-1:0]   cur_qx;
        logic [Q_W-1:0]   cur_qy;
        logic [SQ_W-1:0]  cur_den;
        tctu_side_t       cur_side;
        logic [NUM_W-1:0] dsh;
        logic             take_x;
        logic             take_y;

        if (g == 0) begin : g_head
            assign cur_vld  = in_valid;
            assign cur_rx   = in_num_x;
            assign cur_ry   = in_num_y;
            assign cur_qx   = '0;
            assign cur_qy   = '0;
            assign cur_den  = in_den;
            assign cur_side = in_side;
        end
        else begin : g_body
            assign cur_vld  = vld_reg[g-1];
            assign cur_rx   = rx_reg[g-1];
            assign cur_ry   = ry_reg[g-1];
            assign cur_qx   = qx_reg[g-1];
            assign cur_qy   = qy_reg[g-1];
            assign cur_den  = den_reg[g-1];
            assign cur_side = side_reg[g-1];
        end

        assign dsh    = NUM_W'(cur_den) << B;
        assign take_x = cur_rx >= dsh;
        assign take_y = cur_ry >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[g]   <= take_x ? cur_rx - dsh : cur_rx;
                ry_reg[g]   <= take_y ? cur_ry - dsh : cur_ry;
                qx_reg[g]   <= cur_qx | (Q_W'(take_x) << B);
                qy_reg[g]   <= cur_qy | (Q_W'(take_y) << B);
                den_reg[g]  <= cur_den;
                side_reg[g] <= cur_side;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_qx    = qx_reg[Q_W-1];
    assign out_qy    = qy_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

`default_nettype wire

// ===== hdl/tile_collision_test_unit.sv =====
// Tile collision test unit: one object (circle or rectangle) against one square tile.
// Depends on tctu_pkg, tctu_isqrt, tctu_div and assert_macros.svh.
//
// Takes one test word per clock while in_stall is low and returns one result
// word per test, in order. The path from input to the output register is eight
// front stages of geometry (tile bounds, clamp, per-axis deltas, squares),
// thirty square-root stages (one root bit each), one rounding stage, sixteen
// divide stages (one quotient bit each, x and y in parallel) and the final
// select. Every word takes the full path, rectangles too, so order is kept
// without reordering logic. The whole pipeline advances together; a two-entry
// output (result register plus skid word) lets one result wait on out_stall
// while the pipeline keeps taking input, and in_stall rises only when both
// entries are full. tile_size is written through cfg_we/cfg_wdata and should
// only be changed while no test is in flight.
`default_nettype none
`include "assert_macros.svh"

module tile_collision_test_unit #(
    parameter int FRAC_BITS       = 8,
    parameter int TILE_INDEX_BITS = 12
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [tctu_pkg::TS_W-1:0] cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire tctu_pkg::tctu_in_t        in_word,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output tctu_pkg::tctu_out_t            out_word
);
    import tctu_pkg::*;

    localparam int IDXU   = (TILE_INDEX_BITS < IDX_W) ? TILE_INDEX_BITS : IDX_W;
    localparam int SIDE_W = TS_W + FRAC_BITS;
    localparam int EDGE_W = IDXU + SIDE_W + 1;
    localparam int CW     = ((EDGE_W > POS_W + 2) ? EDGE_W : POS_W + 2) + 2;
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << IDXU) - 64'd1);

    logic [TS_W-1:0] tile_size_reg;
    logic            en;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size_reg <= TILE_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            tile_size_reg <= cfg_wdata;
        end
    end

    // ---------------- stage A: capture ----------------
    logic              a_v_reg;
    tctu_in_t          a_w_reg;
    logic [SIDE_W-1:0] a_side_reg;

    // ---------------- stage B: tile origin ----------------
    logic                 b_v_reg;
    tctu_in_t             b_w_reg;
    logic [SIDE_W-1:0]    b_side_reg;
    logic signed [CW-1:0] b_minx_reg, b_miny_reg;
    logic [EDGE_W-1:0]    b_prodx, b_prody;

    assign b_prodx = EDGE_W'(a_w_reg.tile_col & IDX_MASK) * EDGE_W'(a_side_reg);
    assign b_prody = EDGE_W'(a_w_reg.tile_row & IDX_MASK) * EDGE_W'(a_side_reg);

    // ---------------- stage C: far edges, rectangle ends, centres ----------------
    logic                 c_v_reg, c_circ_reg;
    logic [RAD_W-1:0]     c_rad_reg;
    logic signed [CW-1:0] c_minx_reg, c_miny_reg, c_maxx_reg, c_maxy_reg;
    logic signed [CW-1:0] c_px_reg, c_py_reg, c_pxw_reg, c_pyh_reg;
    logic signed [CW-1:0] c_rcx_reg, c_rcy_reg, c_tcx_reg, c_tcy_reg;
    logic signed [CW-1:0] b_sidee, b_px, b_py, b_w, b_h;

    assign b_sidee = CW'(b_side_reg);
    assign b_px    = CW'(b_w_reg.pos_x);
    assign b_py    = CW'(b_w_reg.pos_y);
    assign b_w     = CW'(b_w_reg.rect_width);
    assign b_h     = CW'(b_w_reg.rect_height);

    // ---------------- stage D: clamp, inside test, rectangle span ----------------
    logic                 d_v_reg, d_circ_reg, d_inside_reg, d_gtx_reg, d_gty_reg;
    logic [RAD_W-1:0]     d_rad_reg;
    logic signed [CW-1:0] d_px_reg, d_py_reg, d_minx_reg, d_miny_reg, d_maxx_reg, d_maxy_reg;
    logic signed [CW-1:0] d_cx_reg, d_cy_reg, d_ex_reg, d_ey_reg, d_bx_reg, d_by_reg;
    logic signed [CW-1:0] c_lox, c_loy;

    assign c_lox = (c_px_reg < c_maxx_reg) ? c_px_reg : c_maxx_reg;
    assign c_loy = (c_py_reg < c_maxy_reg) ? c_py_reg : c_maxy_reg;

    // ---------------- stage E: deltas, touched sides, overlaps ----------------
    logic                 e_v_reg, e_circ_reg, e_inside_reg, e_gtx_reg, e_gty_reg;
    logic                 e_top_reg, e_bot_reg, e_left_reg;
    logic [RAD_W-1:0]     e_rad_reg;
    logic signed [CW-1:0] e_dx_reg, e_dy_reg, e_ox_reg, e_oy_reg;

    // ---------------- stage F: radius window, magnitudes, axis pick ----------------
    logic                 f_v_reg, f_circ_reg, f_inside_reg, f_gtx_reg, f_gty_reg;
    logic                 f_top_reg, f_bot_reg, f_left_reg, f_near_reg;
    logic                 f_rhit_reg, f_xaxis_reg, f_sx_reg, f_sy_reg;
    logic [RAD_W-1:0]     f_rad_reg, f_ax_reg, f_ay_reg;
    logic [DEPTH_W-1:0]   f_ox_reg, f_oy_reg;
    logic signed [CW-1:0] e_rade, e_absx, e_absy;

    assign e_rade = CW'({1'b0, e_rad_reg});
    assign e_absx = e_dx_reg[CW-1] ? -e_dx_reg : e_dx_reg;
    assign e_absy = e_dy_reg[CW-1] ? -e_dy_reg : e_dy_reg;

    // ---------------- stage G: squares ----------------
    logic                 g_v_reg, g_circ_reg, g_inside_reg, g_gtx_reg, g_gty_reg;
    logic                 g_top_reg, g_bot_reg, g_left_reg, g_near_reg;
    logic                 g_rhit_reg, g_xaxis_reg, g_sx_reg, g_sy_reg;
    logic [RAD_W-1:0]     g_rad_reg, g_ax_reg, g_ay_reg;
    logic [DEPTH_W-1:0]   g_ox_reg, g_oy_reg;
    logic [2*RAD_W-1:0]   g_ax2_reg, g_ay2_reg, g_rad2_reg;

    // ---------------- stage H: contact decision, fixed-case results ----------------
    logic               h_v_reg;
    tctu_side_t         h_side_reg;
    logic [SQ_IN_W-1:0] h_sq_in_reg;
    logic [D2_W-1:0]    g_d2;
    logic               g_chit, g_zero;
    tctu_side_t         g_side;

    assign g_d2   = D2_W'(g_ax2_reg) + D2_W'(g_ay2_reg);
    assign g_chit = g_near_reg && (g_d2 <= D2_W'(g_rad2_reg));
    assign g_zero = (g_d2 == '0);

    always_comb
    begin
        g_side           = '0;
        g_side.rad       = g_rad_reg;
        g_side.ax        = g_ax_reg;
        g_side.ay        = g_ay_reg;
        g_side.sx        = g_sx_reg;
        g_side.sy        = g_sy_reg;
        if (g_circ_reg)
        begin
            g_side.centre_inside = g_inside_reg;
            g_side.collided      = g_chit;
            if (g_chit && g_zero)
            begin
                // centre on the box: normal from the touched side
                g_side.depth = DEPTH_W'(g_rad_reg);
                if (g_top_reg)
                begin
                    g_side.ny = UNIT_NEG;
                end
                else if (g_bot_reg)
                begin
                    g_side.ny = UNIT_POS;
                end
                else if (g_left_reg)
                begin
                    g_side.nx = UNIT_NEG;
                end
                else
                begin
                    g_side.nx = UNIT_POS;
                end
            end
            else if (g_chit)
            begin
                g_side.need_math = 1'b1;
            end
        end
        else if (g_rhit_reg)
        begin
            g_side.collided = 1'b1;
            if (g_xaxis_reg)
            begin
                g_side.depth = g_ox_reg;
                g_side.nx    = g_gtx_reg ? UNIT_NEG : UNIT_POS;
            end
            else
            begin
                g_side.depth = g_oy_reg;
                g_side.ny    = g_gty_reg ? UNIT_NEG : UNIT_POS;
            end
        end
    end

    // ---------------- square root ----------------
    logic            s_v;
    logic [SQ_W-1:0] s_sq;
    tctu_side_t      s_side;

    tctu_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (h_v_reg),
        .in_val   (h_sq_in_reg),
        .in_side  (h_side_reg),
        .out_valid(s_v),
        .out_root (s_sq),
        .out_side (s_side)
    );

    // ---------------- stage I: rounded distance, divide operands ----------------
    logic             i_v_reg;
    tctu_side_t       i_side_reg;
    logic [NUM_W-1:0] i_nx_reg, i_ny_reg;
    logic [SQ_W-1:0]  i_den_reg;
    logic [SQ_W-1:0]  s_dis;
    tctu_side_t       s_side_upd;

    assign s_dis = (s_sq + DIST_ROUND) >> UNIT_SHIFT;

    always_comb
    begin
        s_side_upd = s_side;
        if (s_side.need_math)
        begin
            s_side_upd.depth = DEPTH_W'(s_side.rad) - DEPTH_W'(s_dis);
        end
    end

    // ---------------- normal division ----------------
    logic           q_v;
    logic [Q_W-1:0] q_x, q_y;
    tctu_side_t     q_side;

    tctu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (i_v_reg),
        .in_num_x (i_nx_reg),
        .in_num_y (i_ny_reg),
        .in_den   (i_den_reg),
        .in_side  (i_side_reg),
        .out_valid(q_v),
        .out_qx   (q_x),
        .out_qy   (q_y),
        .out_side (q_side)
    );

    // ---------------- stage J: final result ----------------
    logic                    j_v_reg;
    tctu_out_t               j_word_reg;
    logic signed [VEC_W-1:0] q_nx, q_ny;
    tctu_out_t               q_word;

    always_comb
    begin
        q_nx = q_side.nx;
        q_ny = q_side.ny;
        if (q_side.need_math)
        begin
            q_nx = q_side.sx ? -$signed(q_x) : $signed(q_x);
            q_ny = q_side.sy ? -$signed(q_y) : $signed(q_y);
        end
        q_word.collided      = q_side.collided;
        q_word.centre_inside = q_side.centre_inside;
        q_word.overlap_depth = q_side.depth;
        q_word.normal_x      = q_nx;
        q_word.normal_y      = q_ny;
        q_word.tangent_x     = q_ny;
        q_word.tangent_y     = -q_nx;
    end

    // ---------------- output register and skid word ----------------
    logic      out_v_reg, skid_v_reg;
    tctu_out_t out_word_reg, skid_word_reg;

    // pipeline moves whenever the skid word is free
    assign en        = !skid_v_reg;
    assign in_stall  = skid_v_reg;
    assign out_valid = out_v_reg;
    assign out_word  = out_word_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            c_v_reg    <= 1'b0;
            d_v_reg    <= 1'b0;
            e_v_reg    <= 1'b0;
            f_v_reg    <= 1'b0;
            g_v_reg    <= 1'b0;
            h_v_reg    <= 1'b0;
            i_v_reg    <= 1'b0;
            j_v_reg    <= 1'b0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                a_v_reg <= in_valid;
                b_v_reg <= a_v_reg;
                c_v_reg <= b_v_reg;
                d_v_reg <= c_v_reg;
                e_v_reg <= d_v_reg;
                f_v_reg <= e_v_reg;
                g_v_reg <= f_v_reg;
                h_v_reg <= g_v_reg;
                i_v_reg <= s_v;
                j_v_reg <= q_v;
                if (j_v_reg)
                begin
                    if (out_v_reg && out_stall)
                    begin
                        skid_v_reg <= 1'b1;
                    end
                    else
                    begin
                        out_v_reg <= 1'b1;
                    end
                end
                else if (!out_stall)
                begin
                    out_v_reg <= 1'b0;
                end
            end
            else if (!out_stall)
            begin
                // skid word moves up; output stays valid
                skid_v_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_w_reg    <= in_word;
            a_side_reg <= SIDE_W'(tile_size_reg) << FRAC_BITS;

            b_w_reg    <= a_w_reg;
            b_side_reg <= a_side_reg;
            b_minx_reg <= CW'(b_prodx);
            b_miny_reg <= CW'(b_prody);

            c_circ_reg <= b_w_reg.is_circle;
            c_rad_reg  <= b_w_reg.circle_radius;
            c_minx_reg <= b_minx_reg;
            c_miny_reg <= b_miny_reg;
            c_maxx_reg <= b_minx_reg + b_sidee;
            c_maxy_reg <= b_miny_reg + b_sidee;
            c_px_reg   <= b_px;
            c_py_reg   <= b_py;
            c_pxw_reg  <= b_px + b_w;
            c_pyh_reg  <= b_py + b_h;
            c_rcx_reg  <= (b_px <<< 1) + b_w;
            c_rcy_reg  <= (b_py <<< 1) + b_h;
            c_tcx_reg  <= (b_minx_reg <<< 1) + b_sidee;
            c_tcy_reg  <= (b_miny_reg <<< 1) + b_sidee;

            d_circ_reg   <= c_circ_reg;
            d_rad_reg    <= c_rad_reg;
            d_px_reg     <= c_px_reg;
            d_py_reg     <= c_py_reg;
            d_minx_reg   <= c_minx_reg;
            d_miny_reg   <= c_miny_reg;
            d_maxx_reg   <= c_maxx_reg;
            d_maxy_reg   <= c_maxy_reg;
            d_cx_reg     <= (c_lox > c_minx_reg) ? c_lox : c_minx_reg;
            d_cy_reg     <= (c_loy > c_miny_reg) ? c_loy : c_miny_reg;
            d_inside_reg <= (c_px_reg >= c_minx_reg) && (c_px_reg <= c_maxx_reg) &&
                            (c_py_reg >= c_miny_reg) && (c_py_reg <= c_maxy_reg);
            d_ex_reg     <= (c_pxw_reg < c_maxx_reg) ? c_pxw_reg : c_maxx_reg;
            d_ey_reg     <= (c_pyh_reg < c_maxy_reg) ? c_pyh_reg : c_maxy_reg;
            d_bx_reg     <= (c_px_reg > c_minx_reg) ? c_px_reg : c_minx_reg;
            d_by_reg     <= (c_py_reg > c_miny_reg) ? c_py_reg : c_miny_reg;
            d_gtx_reg    <= c_rcx_reg > c_tcx_reg;
            d_gty_reg    <= c_rcy_reg > c_tcy_reg;

            e_circ_reg   <= d_circ_reg;
            e_rad_reg    <= d_rad_reg;
            e_inside_reg <= d_inside_reg;
            e_gtx_reg    <= d_gtx_reg;
            e_gty_reg    <= d_gty_reg;
            e_dx_reg     <= d_px_reg - d_cx_reg;
            e_dy_reg     <= d_py_reg - d_cy_reg;
            e_top_reg    <= d_cy_reg == d_miny_reg;
            e_bot_reg    <= d_cy_reg == d_maxy_reg;
            e_left_reg   <= d_cx_reg == d_minx_reg;
            e_ox_reg     <= d_ex_reg - d_bx_reg;
            e_oy_reg     <= d_ey_reg - d_by_reg;

            f_circ_reg   <= e_circ_reg;
            f_rad_reg    <= e_rad_reg;
            f_inside_reg <= e_inside_reg;
            f_gtx_reg    <= e_gtx_reg;
            f_gty_reg    <= e_gty_reg;
            f_top_reg    <= e_top_reg;
            f_bot_reg    <= e_bot_reg;
            f_left_reg   <= e_left_reg;
            f_near_reg   <= (e_absx <= e_rade) && (e_absy <= e_rade);
            f_ax_reg     <= e_absx[RAD_W-1:0];
            f_ay_reg     <= e_absy[RAD_W-1:0];
            f_sx_reg     <= e_dx_reg[CW-1];
            f_sy_reg     <= e_dy_reg[CW-1];
            f_rhit_reg   <= !e_ox_reg[CW-1] && !e_oy_reg[CW-1];
            f_xaxis_reg  <= e_ox_reg < e_oy_reg;
            f_ox_reg     <= e_ox_reg[DEPTH_W-1:0];
            f_oy_reg     <= e_oy_reg[DEPTH_W-1:0];

            g_circ_reg   <= f_circ_reg;
            g_rad_reg    <= f_rad_reg;
            g_inside_reg <= f_inside_reg;
            g_gtx_reg    <= f_gtx_reg;
            g_gty_reg    <= f_gty_reg;
            g_top_reg    <= f_top_reg;
            g_bot_reg    <= f_bot_reg;
            g_left_reg   <= f_left_reg;
            g_near_reg   <= f_near_reg;
            g_ax_reg     <= f_ax_reg;
            g_ay_reg     <= f_ay_reg;
            g_sx_reg     <= f_sx_reg;
            g_sy_reg     <= f_sy_reg;
            g_rhit_reg   <= f_rhit_reg;
            g_xaxis_reg  <= f_xaxis_reg;
            g_ox_reg     <= f_ox_reg;
            g_oy_reg     <= f_oy_reg;
            g_ax2_reg    <= f_ax_reg * f_ax_reg;
            g_ay2_reg    <= f_ay_reg * f_ay_reg;
            g_rad2_reg   <= f_rad_reg * f_rad_reg;

            h_side_reg   <= g_side;
            h_sq_in_reg  <= SQ_IN_W'(g_d2[2*RAD_W-1:0]) << SQ_SCALE;

            i_side_reg   <= s_side_upd;
            i_nx_reg     <= (NUM_W'(s_side.ax) << SQ_SCALE) + NUM_W'(s_sq >> 1);
            i_ny_reg     <= (NUM_W'(s_side.ay) << SQ_SCALE) + NUM_W'(s_sq >> 1);
            i_den_reg    <= s_sq;

            j_word_reg   <= q_word;

            if (j_v_reg && out_v_reg && out_stall)
            begin
                skid_word_reg <= j_word_reg;
            end
            else if (j_v_reg)
            begin
                out_word_reg <= j_word_reg;
            end
        end
        else if (!out_stall)
        begin
            out_word_reg <= skid_word_reg;
        end
    end

    // ---------------- checks ----------------
    `TCTU_ASSERT_IMP(a_skid_needs_out, skid_v_reg, out_v_reg,
        "skid word held without a valid output word")
    `TCTU_ASSERT_IMP(a_miss_is_zero, out_v_reg && !out_word_reg.collided,
        out_word_reg.overlap_depth == '0 && out_word_reg.normal_x == '0 &&
        out_word_reg.normal_y == '0, "no contact but nonzero depth or normal")
    `TCTU_ASSERT_IMP(a_inside_hits, out_v_reg && out_word_reg.centre_inside,
        out_word_reg.collided, "centre inside the tile without contact")

endmodule

`default_nettype wire
